FILE: src/cpev_pkg.sv
// Shared types and constants of the coalescing priority event dispatcher.
// No dependencies; cpev_qptr, the top level and the testbench import this package.
`timescale 1ns / 1ps

package cpev_pkg;

   // Fixed field widths
   localparam int CLASS_COUNT = 7;
   localparam int CLS_W       = 3;
   localparam int KIND_W      = 3;
   localparam int ID_W        = 6;
   localparam int ID_SPACE    = 64;            // ids a subject field can name
   localparam int ENTRY_W     = KIND_W + ID_W; // queue entry: {kind, id}
   localparam int ROW_W       = 2 * ID_SPACE;  // mark row: {rearm, queued}
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;
   localparam int MODE_W      = 2;

   // Request opcodes, carried on req_tuser
   typedef enum logic [MODE_W-1:0] {
      MODE_POST   = 2'd0,
      MODE_TAKE   = 2'd1,
      MODE_FINISH = 2'd2,
      MODE_FAIL   = 2'd3
   } mode_type;

   // Command to the queue pointer block
   typedef struct packed {
      logic             push;
      logic             pop;
      logic             flush;
      logic [CLS_W-1:0] cls;
   } qptr_cmd_type;

endpackage

FILE: src/cpev_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cpev_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cpev_qptr.sv
// Head and count registers of the seven class FIFOs, with tail and full lookup.
// Depends on cpev_pkg.
`timescale 1ns / 1ps

module cpev_qptr #(
   parameter int SUBJECT_COUNT = 64,
   parameter int HW = $clog2(SUBJECT_COUNT)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cpev_pkg::qptr_cmd_type        cmd,
   input  logic [cpev_pkg::CLS_W-1:0]    sel_cls,
   output logic [HW-1:0]                 head,
   output logic [HW-1:0]                 tail,
   output logic                          full,
   output logic [cpev_pkg::CLASS_COUNT-1:0] nonempty,
   output logic [cpev_pkg::CLASS_COUNT-1:0] nonempty_next
);
   import cpev_pkg::*;

   localparam int CW = $clog2(SUBJECT_COUNT + 1);
   localparam int SW = HW + 1;

   logic [CW-1:0]    counts_ff [CLASS_COUNT];
   logic [CW-1:0]    counts_in [CLASS_COUNT];
   logic [HW-1:0]    heads_ff  [CLASS_COUNT];
   logic [HW-1:0]    heads_in  [CLASS_COUNT];
   logic [CLS_W-1:0] sidx;
   logic [CW-1:0]    scnt;
   logic [SW-1:0]    tsum;

   // next pointers per class
   always_comb begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
         logic          hit;
         logic [SW-1:0] hinc;
         hit  = (cmd.cls == CLS_W'(c));
         hinc = SW'(heads_ff[c]) + SW'(1);
         counts_in[c] = counts_ff[c];
         heads_in[c]  = heads_ff[c];
         if (cmd.flush) begin
            counts_in[c] = '0;
            heads_in[c]  = '0;
         end else if (cmd.push && hit) begin
            counts_in[c] = counts_ff[c] + CW'(1);
         end else if (cmd.pop && hit) begin
            counts_in[c] = counts_ff[c] - CW'(1);
            heads_in[c]  = (hinc == SW'(SUBJECT_COUNT)) ? '0 : HW'(hinc);
         end
         nonempty[c]      = (counts_ff[c] != '0);
         nonempty_next[c] = (counts_in[c] != '0);
      end
   end

   // lookup for the selected class; class seven maps to the slot of class zero
   always_comb begin
      sidx = (sel_cls < CLS_W'(CLASS_COUNT)) ? sel_cls : '0;
      head = heads_ff[sidx];
      scnt = counts_ff[sidx];
      full = (scnt == CW'(SUBJECT_COUNT));
      tsum = SW'(head) + SW'(scnt);
      tail = (tsum >= SW'(SUBJECT_COUNT)) ? HW'(tsum - SW'(SUBJECT_COUNT)) : HW'(tsum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CLASS_COUNT; c++) begin
            counts_ff[c] <= '0;
            heads_ff[c]  <= '0;
         end
      end else begin
         for (int c = 0; c < CLASS_COUNT; c++) begin
            counts_ff[c] <= counts_in[c];
            heads_ff[c]  <= heads_in[c];
         end
      end
   end

endmodule

FILE: src/coalescing_priority_event_dispatcher.sv
// Coalescing strict-priority event dispatcher, top level.
// Depends on cpev_pkg, cpev_ram and cpev_qptr.
`timescale 1ns / 1ps

// Usage
//   req channel: one operation per beat; req_tuser is the opcode (post, take
//   next, finish active, worker request failed), req_tdata the key and kind.
//   rsp channel: exactly one result beat per request; rsp_tuser is set when a
//   take-next delivered an entry, rsp_tdata carries it plus worker status.
//   csr channel: writes the dispatch enable bit; always ready. Write it only
//   while no request is in flight.
// Timing
//   A request is taken in the idle cycle, the mark row and queue entry are read
//   from RAM (registered read), and the execute step then modifies, writes back and
//   loads the result register, which drives rsp_tvalid. A new request is taken
//   only after the previous one has written back, set by the read-then-write
//   pass over the mark RAM.
// Reset
//   Queues empty, all marks clear, no active entry, not running, dispatch
//   disabled. Queue RAM contents need no clearing; mark rows carry a valid bit.
// Backpressure
//   The result register holds while rsp_tready is low; a new request is still
//   taken and read, but its write-back waits until the result register frees.
module coalescing_priority_event_dispatcher #(
   parameter int SUBJECT_COUNT = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] event_class, [5:3] kind tag, [11:6] subject_id
   input  logic [cpev_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] mode
   input  logic [cpev_pkg::MODE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] out_event_class, [5:3] out kind tag, [11:6] out_subject_id,
   // [12] start_worker, [13] running_now, [14] any_pending
   output logic [cpev_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] granted
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_data
);
   import cpev_pkg::*;

   localparam int HW     = $clog2(SUBJECT_COUNT);
   localparam int QDEPTH = CLASS_COUNT * SUBJECT_COUNT;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int MAW    = $clog2(CLASS_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   mode_type         op_ff;
   logic [CLS_W-1:0] cls_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [ID_W-1:0]  id_ff;
   logic [CLS_W-1:0] mrow_cls_ff;
   logic             en_ff;
   logic             act_vld_ff, act_vld_in;
   logic [CLS_W-1:0] act_cls_ff, act_cls_in;
   logic [KIND_W-1:0] act_kind_ff, act_kind_in;
   logic [ID_W-1:0]  act_id_ff, act_id_in;
   logic             running_ff, running_in;
   logic [CLASS_COUNT-1:0] row_vld_ff;
   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic             rsp_user_ff;

   logic             accept, go;
   mode_type         in_mode;
   logic [CLS_W-1:0] in_cls;
   logic [KIND_W-1:0] in_kind;
   logic [ID_W-1:0]  in_id;
   logic             pe_hit;
   logic [CLS_W-1:0] pe_cls;

   qptr_cmd_type     cmd, cmd_go;
   logic [CLS_W-1:0] sel_cls;
   logic [HW-1:0]    q_head, q_tail;
   logic             q_full;
   logic [CLASS_COUNT-1:0] nonempty, nonempty_next;

   logic             mrow_re;
   logic [CLS_W-1:0] mrow_raddr;
   logic [ROW_W-1:0] mrow_rdata, row_cur;
   logic [ID_SPACE-1:0] q_row, r_row;
   logic             row_we;
   logic             q_re, q_we;
   logic [QAW-1:0]   q_raddr, q_waddr;
   logic [ENTRY_W-1:0] q_rdata, q_wdata;
   logic [KIND_W-1:0] e_kind;
   logic [ID_W-1:0]  e_id;
   logic             granted, start;
   logic [CLS_W-1:0] o_cls;
   logic [KIND_W-1:0] o_kind;
   logic [ID_W-1:0]  o_id;

   // request fields
   assign in_mode = mode_type'(req_tuser);
   assign in_cls  = req_tdata[CLS_W-1:0];
   assign in_kind = req_tdata[CLS_W+KIND_W-1:CLS_W];
   assign in_id   = req_tdata[CLS_W+KIND_W+ID_W-1:CLS_W+KIND_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign go         = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // highest-priority non-empty class
   always_comb begin
      pe_hit = |nonempty;
      pe_cls = '0;
      for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
         if (nonempty[c]) begin
            pe_cls = CLS_W'(c);
         end
      end
   end

   // read issue in the accept cycle
   always_comb begin
      mrow_re    = 1'b0;
      mrow_raddr = in_cls;
      case (in_mode)
         MODE_POST: begin
            mrow_re = (in_cls < CLS_W'(CLASS_COUNT));
         end
         MODE_TAKE: begin
            mrow_re    = pe_hit;
            mrow_raddr = pe_cls;
         end
         MODE_FINISH: begin
            mrow_re    = 1'b1;
            mrow_raddr = act_cls_ff;
         end
         default: begin
            mrow_re = 1'b0;
         end
      endcase
      mrow_re = mrow_re && accept;
      q_re    = accept && (in_mode == MODE_TAKE) && pe_hit;
      q_raddr = QAW'(pe_cls) * QAW'(SUBJECT_COUNT) + QAW'(q_head);
   end

   assign sel_cls = (state_ff == ST_IDLE) ? pe_cls :
                    (op_ff == MODE_FINISH) ? act_cls_ff : cls_ff;

   // modify step on the read row and entry
   always_comb begin
      row_cur = '0;
      if (mrow_cls_ff < CLS_W'(CLASS_COUNT)) begin
         if (row_vld_ff[mrow_cls_ff]) begin
            row_cur = mrow_rdata;
         end
      end
      q_row       = row_cur[ID_SPACE-1:0];
      r_row       = row_cur[ROW_W-1:ID_SPACE];
      e_kind      = q_rdata[ENTRY_W-1:ID_W];
      e_id        = q_rdata[ID_W-1:0];
      cmd         = '0;
      row_we      = 1'b0;
      q_we        = 1'b0;
      q_waddr     = QAW'(cls_ff) * QAW'(SUBJECT_COUNT) + QAW'(q_tail);
      q_wdata     = {kind_ff, id_ff};
      act_vld_in  = act_vld_ff;
      act_cls_in  = act_cls_ff;
      act_kind_in = act_kind_ff;
      act_id_in   = act_id_ff;
      running_in  = running_ff;
      granted     = 1'b0;
      start       = 1'b0;
      o_cls       = '0;
      o_kind      = '0;
      o_id        = '0;
      case (op_ff)
         MODE_POST: begin
            if (en_ff) begin
               if (act_vld_ff && act_cls_ff == cls_ff && act_id_ff == id_ff) begin
                  r_row[id_ff] = 1'b1;
                  row_we       = 1'b1;
               end else if (cls_ff < CLS_W'(CLASS_COUNT) && int'(id_ff) < SUBJECT_COUNT
                            && !q_row[id_ff] && !r_row[id_ff] && !q_full) begin
                  cmd.push     = 1'b1;
                  cmd.cls      = cls_ff;
                  q_we         = 1'b1;
                  q_row[id_ff] = 1'b1;
                  row_we       = 1'b1;
               end
               if (!running_ff) begin
                  running_in = 1'b1;
                  start      = 1'b1;
               end
            end
         end
         MODE_TAKE: begin
            if (!pe_hit) begin
               running_in = 1'b0;
            end else begin
               cmd.pop     = 1'b1;
               cmd.cls     = pe_cls;
               act_cls_in  = pe_cls;
               act_kind_in = e_kind;
               act_id_in   = e_id;
               if (en_ff) begin
                  q_row[e_id] = 1'b0;
                  row_we      = 1'b1;
                  act_vld_in  = 1'b1;
                  granted     = 1'b1;
                  o_cls       = pe_cls;
                  o_kind      = e_kind;
                  o_id        = e_id;
               end else begin
                  // disabled: drop the popped entry and flush everything
                  cmd.flush  = 1'b1;
                  act_vld_in = 1'b0;
                  running_in = 1'b0;
               end
            end
         end
         MODE_FINISH: begin
            if (act_vld_ff) begin
               act_vld_in = 1'b0;
               if (r_row[act_id_ff]) begin
                  r_row[act_id_ff] = 1'b0;
                  row_we           = 1'b1;
                  if (!q_row[act_id_ff] && !q_full) begin
                     cmd.push         = 1'b1;
                     cmd.cls          = act_cls_ff;
                     q_we             = 1'b1;
                     q_waddr          = QAW'(act_cls_ff) * QAW'(SUBJECT_COUNT)
                                        + QAW'(q_tail);
                     q_wdata          = {act_kind_ff, act_id_ff};
                     q_row[act_id_ff] = 1'b1;
                  end
               end
               if (!(|nonempty_next)) begin
                  running_in = 1'b0;
               end
            end
         end
         default: begin
            running_in = 1'b0;
         end
      endcase
      cmd_go = go ? cmd : '0;
   end

   cpev_qptr #(
      .SUBJECT_COUNT (SUBJECT_COUNT)
   ) u_qptr (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd_go),
      .sel_cls       (sel_cls),
      .head          (q_head),
      .tail          (q_tail),
      .full          (q_full),
      .nonempty      (nonempty),
      .nonempty_next (nonempty_next)
   );

   // class FIFO storage
   cpev_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QDEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we && go),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   // queued and rearm marks, one row per class
   cpev_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CLASS_COUNT)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (row_we && go && !cmd.flush),
      .wr_addr (MAW'(mrow_cls_ff)),
      .wr_data ({r_row, q_row}),
      .rd_en   (mrow_re),
      .rd_addr (MAW'(mrow_raddr)),
      .rd_data (mrow_rdata)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_ff        <= 1'b0;
         act_vld_ff   <= 1'b0;
         act_cls_ff   <= '0;
         act_kind_ff  <= '0;
         act_id_ff    <= '0;
         running_ff   <= 1'b0;
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            en_ff <= csr_data;
         end
         if (go) begin
            act_vld_ff  <= act_vld_in;
            act_cls_ff  <= act_cls_in;
            act_kind_ff <= act_kind_in;
            act_id_ff   <= act_id_in;
            running_ff  <= running_in;
            if (cmd.flush) begin
               row_vld_ff <= '0;
            end else if (row_we) begin
               row_vld_ff[MAW'(mrow_cls_ff)] <= 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= in_mode;
         cls_ff      <= in_cls;
         kind_ff     <= in_kind;
         id_ff       <= in_id;
         mrow_cls_ff <= mrow_raddr;
      end
      if (go) begin
         rsp_data_ff <= {1'b0, |nonempty_next, running_in, start, o_id, o_kind, o_cls};
         rsp_user_ff <= granted;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_grant_needs_enable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> en_ff)
      else $error("entry granted while dispatch disabled");

   a_start_implies_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[12]) |-> rsp_tdata[13])
      else $error("worker start reported without running flag");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not enter execute step");
`endif

endmodule

FILE: verif/coalescing_priority_event_dispatcher_tb.sv
// Self-checking testbench for the coalescing priority event dispatcher.
// Depends on cpev_pkg and the dispatcher RTL; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module coalescing_priority_event_dispatcher_tb;
   import cpev_pkg::*;

   // Predicts the dispatcher and holds the result beats still owed
   class dispatch_scoreboard;
      bit          enable;
      bit [2:0]    fifo_kind [CLASS_COUNT][ID_SPACE];
      bit [5:0]    fifo_id   [CLASS_COUNT][ID_SPACE];
      int          head      [CLASS_COUNT];
      int          count     [CLASS_COUNT];
      bit          queued    [CLASS_COUNT][ID_SPACE];
      bit          rearm     [CLASS_COUNT][ID_SPACE];
      bit [2:0]    act_cls;
      bit [2:0]    act_kind;
      bit [5:0]    act_id;
      bit          act_valid;
      bit          running;
      bit [15:0]   owed_data [16];
      bit          owed_user [16];
      bit [3:0]    owed_wr;
      bit [3:0]    owed_rd;
      int          owed;
      int          errors;

      function void clear_queues();
         for (int c = 0; c < CLASS_COUNT; c++) begin
            head[c]  = 0;
            count[c] = 0;
            for (int i = 0; i < ID_SPACE; i++) begin
               queued[c][i] = 0;
               rearm[c][i]  = 0;
            end
         end
      endfunction

      function bit pending();
         for (int c = 0; c < CLASS_COUNT; c++)
            if (count[c] != 0) return 1;
         return 0;
      endfunction

      function void push(bit [2:0] c, bit [2:0] k, bit [5:0] i);
         int tail;
         if (count[c] >= ID_SPACE) return;
         tail = (head[c] + count[c]) % ID_SPACE;
         fifo_kind[c][tail] = k;
         fifo_id[c][tail]   = i;
         count[c]++;
         queued[c][i] = 1;
      endfunction

      // Apply one accepted request beat and record the result it owes
      function void note_request(mode_type mode, bit [2:0] cls, bit [2:0] kind, bit [5:0] id);
         bit       granted;
         bit       start;
         bit [2:0] o_cls;
         bit [2:0] o_kind;
         bit [5:0] o_id;
         int       c;
         granted = 0; start = 0; o_cls = 0; o_kind = 0; o_id = 0;
         case (mode)
            MODE_POST: begin
               if (enable) begin
                  if (act_valid && act_cls == cls && act_id == id)
                     rearm[cls][id] = 1;
                  else if (cls < CLASS_COUNT && !queued[cls][id] && !rearm[cls][id])
                     push(cls, kind, id);
                  if (!running) begin
                     running = 1;
                     start   = 1;
                  end
               end
            end
            MODE_TAKE: begin
               c = 0;
               while (c < CLASS_COUNT && count[c] == 0) c++;
               if (c == CLASS_COUNT) begin
                  running = 0;
               end else begin
                  act_cls  = 3'(c);
                  act_kind = fifo_kind[c][head[c]];
                  act_id   = fifo_id[c][head[c]];
                  head[c]  = (head[c] + 1) % ID_SPACE;
                  count[c]--;
                  queued[c][act_id] = 0;
                  act_valid = 1;
                  if (!enable) begin
                     clear_queues();
                     act_valid = 0;
                     running   = 0;
                  end else begin
                     granted = 1;
                     o_cls   = act_cls;
                     o_kind  = act_kind;
                     o_id    = act_id;
                  end
               end
            end
            MODE_FINISH: begin
               if (act_valid) begin
                  act_valid = 0;
                  if (rearm[act_cls][act_id]) begin
                     rearm[act_cls][act_id] = 0;
                     if (!queued[act_cls][act_id]) push(act_cls, act_kind, act_id);
                  end
                  if (!pending()) running = 0;
               end
            end
            default: running = 0;
         endcase
         owed_data[owed_wr] = {1'b0, pending(), running, start, o_id, o_kind, o_cls};
         owed_user[owed_wr] = granted;
         owed_wr++;
         owed++;
      endfunction

      // Compare one result beat with the oldest owed one, field by field
      function void check_result(bit [15:0] data, bit user);
         bit [15:0] ed;
         bit        eu;
         if (owed == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: data %h user %b", data, user);
            return;
         end
         ed = owed_data[owed_rd];
         eu = owed_user[owed_rd];
         owed_rd++;
         owed--;
         if (eu != user || ed[2:0] != data[2:0] || ed[5:3] != data[5:3] ||
             ed[11:6] != data[11:6] || ed[12] != data[12] || ed[13] != data[13] ||
             ed[14] != data[14] || data[15] != 1'b0) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: exp granted %b cls %0d kind %0d id %0d start %b run %b pend %b",
                        eu, ed[2:0], ed[5:3], ed[11:6], ed[12], ed[13], ed[14]);
               $display("  got granted %b cls %0d kind %0d id %0d start %b run %b pend %b pad %b",
                        user, data[2:0], data[5:3], data[11:6], data[12], data[13],
                        data[14], data[15]);
            end
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 5000;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [MODE_W-1:0]      req_tuser = MODE_POST;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 0;
   logic                   csr_ready;
   logic                   csr_data = 0;

   dispatch_scoreboard board;
   int  send_idle_pct  = 0;
   int  stall_pct      = 0;
   int  quiet_cycles   = 0;
   bit  in_reset       = 1;

   coalescing_priority_event_dispatcher #(.SUBJECT_COUNT(64)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Receiver backpressure
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Monitor accepted beats on every channel, plus the stall watchdog
   always @(posedge clock) begin
      if (!in_reset) begin
         if (req_tvalid && req_tready)
            board.note_request(mode_type'(req_tuser), req_tdata[2:0], req_tdata[5:3],
                               req_tdata[11:6]);
         if (csr_valid && csr_ready) board.enable = csr_data;
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // One request beat, with a random sender gap ahead of it
   task automatic send_op(mode_type mode, bit [2:0] cls, bit [2:0] kind, bit [5:0] id);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, id, kind, cls};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drain all owed results, let the pipeline settle, then write the enable bit
   task automatic write_enable(bit value);
      @(negedge clock);
      req_tvalid <= 0;
      while (board.owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_op();
      int        r;
      mode_type  mode;
      bit [2:0]  cls;
      bit [5:0]  id;
      r = int'($urandom_range(99));
      if (r < 45)      mode = MODE_POST;
      else if (r < 75) mode = MODE_TAKE;
      else if (r < 95) mode = MODE_FINISH;
      else             mode = MODE_FAIL;
      // Mostly a small key pool so posts coalesce and hit the active key
      cls = ($urandom_range(9) == 0) ? 3'd7 : $urandom_range(1, 0) ? 3'($urandom_range(1))
                                                                   : 3'($urandom_range(6));
      id  = ($urandom_range(9) < 7) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
      send_op(mode, cls, 3'($urandom_range(7)), id);
   endtask

   initial begin
      board = new();
      board.clear_queues();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset    <= 0;
      in_reset = 0;

      // Disabled after reset: post dropped, empty take, finish idle, failed worker
      send_op(MODE_POST, 3'd0, 3'd1, 6'd5);
      send_op(MODE_TAKE, 3'd0, 3'd0, 6'd0);
      send_op(MODE_FINISH, 3'd0, 3'd0, 6'd0);
      send_op(MODE_FAIL, 3'd0, 3'd0, 6'd0);
      write_enable(1);
      send_op(MODE_POST, 3'd6, 3'd7, 6'd63);   // first post starts a worker
      send_op(MODE_POST, 3'd0, 3'd0, 6'd0);
      send_op(MODE_POST, 3'd0, 3'd5, 6'd0);    // same key coalesces
      send_op(MODE_POST, 3'd7, 3'd2, 6'd9);    // class seven queues nothing
      send_op(MODE_POST, 3'd3, 3'd4, 6'd42);
      send_op(MODE_TAKE, 3'd0, 3'd0, 6'd0);    // class 0 first
      send_op(MODE_POST, 3'd0, 3'd6, 6'd0);    // active key: mark rearm
      send_op(MODE_POST, 3'd0, 3'd6, 6'd0);    // absorbed by the rearm mark
      send_op(MODE_TAKE, 3'd0, 3'd0, 6'd0);    // replaces the active entry
      send_op(MODE_FINISH, 3'd0, 3'd0, 6'd0);
      send_op(MODE_FINISH, 3'd0, 3'd0, 6'd0);  // nothing active
      send_op(MODE_TAKE, 3'd0, 3'd0, 6'd0);
      send_op(MODE_TAKE, 3'd0, 3'd0, 6'd0);
      send_op(MODE_TAKE, 3'd0, 3'd0, 6'd0);    // all empty
      send_op(MODE_FAIL, 3'd0, 3'd0, 6'd0);
      send_op(MODE_POST, 3'd2, 3'd3, 6'd1);
      send_op(MODE_POST, 3'd2, 3'd3, 6'd2);
      write_enable(0);
      send_op(MODE_TAKE, 3'd0, 3'd0, 6'd0);    // disabled take flushes
      send_op(MODE_TAKE, 3'd0, 3'd0, 6'd0);

      // Random phases over idle patterns and enable settings
      for (int p = 0; p < 8; p++) begin
         write_enable((p == 3 || p == 6) ? 1'b0 : 1'b1);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         repeat (225) random_op();
      end

      @(negedge clock);
      req_tvalid <= 0;
      while (board.owed != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (board.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
src/cpev_pkg.sv
src/cpev_ram.sv
src/cpev_qptr.sv
src/coalescing_priority_event_dispatcher.sv
verif/coalescing_priority_event_dispatcher_tb.sv
